// ===== rtl/wsh_pkg.sv =====
`default_nettype none

package wsh_pkg;

    localparam int DATA_BITS    = 8;
    localparam int POS_BITS     = 16;
    localparam int CONS_BITS    = 16;
    localparam int STATUS_BITS  = 3;
    localparam int KEY_CHARS    = 28;
    localparam int KEY_PART_CHARS = 7;
    localparam int KEY_PART_BITS  = KEY_PART_CHARS * DATA_BITS;
    localparam int KEY_BITS     = KEY_CHARS * DATA_BITS;
    localparam int KEY_IDX_BITS = 5;
    localparam int NAME_LEN     = 21;
    localparam int NAME_IDX_BITS = 5;
    localparam int CRLF_BITS    = 3;
    localparam int CFG_IDX_BITS = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int M_TDATA_BITS = 24;

    localparam logic [DATA_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_BITS-1:0] CH_S     = 8'h53;
    localparam logic [DATA_BITS-1:0] CH_ONE   = 8'h31;
    localparam logic [DATA_BITS-1:0] CH_ZERO  = 8'h30;

    localparam logic [CRLF_BITS-1:0] CRLF_LINE_START = 3'd2;
    localparam logic [CRLF_BITS-1:0] CRLF_MSG_END    = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_UNEXP_END    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_LINE     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_CODE_NOT_101 = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_KEY_MISMATCH = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_PART0 = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_PART1 = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_PART2 = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KEY_PART3 = 8'd3;

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_KEY    = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    // one classified byte, as it travels from front to back
    typedef struct packed {
        logic                 mode;
        logic [DATA_BITS-1:0] data_byte;
        logic [DATA_BITS-1:0] lc_byte;
        logic                 is_cr;
        logic                 is_lf;
        logic                 is_space;
        logic                 is_upper_s;
    } beat_t;

    // lowercase "sec-websocket-accept:"
    function automatic logic [DATA_BITS-1:0] name_char(input logic [NAME_IDX_BITS-1:0] idx);
        logic [DATA_BITS-1:0] c;
        unique case (idx)
            5'd0:    c = "s";
            5'd1:    c = "e";
            5'd2:    c = "c";
            5'd3:    c = "-";
            5'd4:    c = "w";
            5'd5:    c = "e";
            5'd6:    c = "b";
            5'd7:    c = "s";
            5'd8:    c = "o";
            5'd9:    c = "c";
            5'd10:   c = "k";
            5'd11:   c = "e";
            5'd12:   c = "t";
            5'd13:   c = "-";
            5'd14:   c = "a";
            5'd15:   c = "c";
            5'd16:   c = "c";
            5'd17:   c = "e";
            5'd18:   c = "p";
            5'd19:   c = "t";
            5'd20:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wsh_front.sv =====
`default_nettype none

module wsh_front (
    input  wire logic                          mode,
    input  wire logic [wsh_pkg::DATA_BITS-1:0] data_byte,
    output wsh_pkg::beat_t                     beat
);

    always_comb begin
        beat.mode       = mode;
        beat.data_byte  = data_byte;
        beat.is_cr      = (data_byte == wsh_pkg::CH_CR);
        beat.is_lf      = (data_byte == wsh_pkg::CH_LF);
        beat.is_space   = (data_byte == wsh_pkg::CH_SPACE);
        beat.is_upper_s = (data_byte == wsh_pkg::CH_S);
        if (data_byte >= 8'h41 && data_byte <= 8'h5A) begin
            beat.lc_byte = data_byte + 8'h20;
        end else begin
            beat.lc_byte = data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsh_queue.sv =====
`default_nettype none

module wsh_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire wsh_pkg::beat_t in_beat,
    output logic                out_valid,
    input  wire logic           out_ready,
    output wsh_pkg::beat_t      out_beat
);

    wsh_pkg::beat_t                 mem [wsh_pkg::QUEUE_DEPTH];
    logic [wsh_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [wsh_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [wsh_pkg::QPTR_BITS:0]    count_reg, count_next;
    logic                           push, pop;

    assign in_ready  = (count_reg != (wsh_pkg::QPTR_BITS+1)'(wsh_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_beat  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + (wsh_pkg::QPTR_BITS)'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + (wsh_pkg::QPTR_BITS)'(1) : rd_ptr_reg;
        count_next  = count_reg + (wsh_pkg::QPTR_BITS+1)'(push)
                      - (wsh_pkg::QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wsh_back.sv =====
`default_nettype none

module wsh_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [wsh_pkg::KEY_BITS-1:0]    key_vec,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire wsh_pkg::beat_t                  beat,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [wsh_pkg::STATUS_BITS-1:0]      out_status,
    output logic [wsh_pkg::CONS_BITS-1:0]        out_consumed
);

    logic [wsh_pkg::CRLF_BITS-1:0]     crlf_reg, crlf_next;
    logic [wsh_pkg::POS_BITS-1:0]      pos_reg, pos_next;
    logic                              space_reg, space_next;
    logic [1:0]                        digits_reg, digits_next;
    logic                              code_ok_reg, code_ok_next;
    wsh_pkg::phase_t                   phase_reg, phase_next;
    logic [wsh_pkg::NAME_IDX_BITS-1:0] name_idx_reg, name_idx_next;
    logic [wsh_pkg::KEY_IDX_BITS-1:0]  key_idx_reg, key_idx_next;
    logic                              key_bad_reg, key_bad_next;

    logic                              out_valid_reg, out_valid_next;
    logic [wsh_pkg::STATUS_BITS-1:0]   status_reg, status_next;
    logic [wsh_pkg::CONS_BITS-1:0]     consumed_reg, consumed_next;

    logic                              take, emit;
    logic [wsh_pkg::DATA_BITS-1:0]     key_byte;

    assign in_ready     = !out_valid_reg || out_ready;
    assign take         = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign out_status   = status_reg;
    assign out_consumed = consumed_reg;
    assign key_byte     = key_vec[{key_idx_reg, 3'b000} +: wsh_pkg::DATA_BITS];

    always_comb begin
        logic                              key_step;
        logic [wsh_pkg::DATA_BITS-1:0]     want;
        key_step      = 1'b0;
        want          = wsh_pkg::CH_ONE;
        crlf_next     = crlf_reg;
        pos_next      = pos_reg;
        space_next    = space_reg;
        digits_next   = digits_reg;
        code_ok_next  = code_ok_reg;
        phase_next    = phase_reg;
        name_idx_next = name_idx_reg;
        key_idx_next  = key_idx_reg;
        key_bad_next  = key_bad_reg;
        emit          = 1'b0;
        status_next   = status_reg;
        consumed_next = consumed_reg;

        if (take && beat.mode) begin
            emit          = 1'b1;
            status_next   = wsh_pkg::ST_UNEXP_END;
            consumed_next = '0;
        end else if (take) begin
            // status code digits after the first space
            if (space_reg) begin
                if (digits_reg != 2'd3) begin
                    want = (digits_reg == 2'd1) ? wsh_pkg::CH_ZERO : wsh_pkg::CH_ONE;
                    if (beat.data_byte != want) begin
                        code_ok_next = 1'b0;
                    end
                    digits_next = digits_reg + 2'd1;
                end
            end else if (beat.is_space && pos_reg != '0) begin
                space_next = 1'b1;
            end

            unique case (phase_reg)
                wsh_pkg::PH_SEARCH: begin
                    if (crlf_reg == wsh_pkg::CRLF_LINE_START && beat.is_upper_s) begin
                        phase_next    = wsh_pkg::PH_NAME;
                        name_idx_next = 5'd1;
                    end
                end
                wsh_pkg::PH_NAME: begin
                    if (beat.lc_byte == wsh_pkg::name_char(name_idx_reg)) begin
                        name_idx_next = name_idx_reg + 5'd1;
                        if (name_idx_next == 5'(wsh_pkg::NAME_LEN)) begin
                            phase_next = wsh_pkg::PH_SKIP;
                        end
                    end else begin
                        phase_next    = wsh_pkg::PH_SEARCH;
                        name_idx_next = '0;
                    end
                end
                wsh_pkg::PH_SKIP: key_step = !beat.is_space;
                wsh_pkg::PH_KEY:  key_step = 1'b1;
                default: ;
            endcase

            if (key_step) begin
                if (beat.data_byte != key_byte) begin
                    key_bad_next = 1'b1;
                end
                key_idx_next = key_idx_reg + 5'd1;
                phase_next   = (key_idx_next == 5'(wsh_pkg::KEY_CHARS)) ?
                               wsh_pkg::PH_DONE : wsh_pkg::PH_KEY;
            end

            // CR and LF only advance in alternation
            if (beat.is_cr) begin
                crlf_next = crlf_reg + {2'b00, !crlf_reg[0]};
            end else if (beat.is_lf) begin
                crlf_next = crlf_reg + {2'b00, crlf_reg[0]};
            end else begin
                crlf_next = '0;
            end

            if (pos_reg != '1) begin
                pos_next = pos_reg + (wsh_pkg::POS_BITS)'(1);
            end

            if (crlf_next == wsh_pkg::CRLF_MSG_END) begin
                emit = 1'b1;
                priority if (!space_next || digits_next != 2'd3) begin
                    status_next = wsh_pkg::ST_BAD_LINE;
                end else if (!code_ok_next) begin
                    status_next = wsh_pkg::ST_CODE_NOT_101;
                end else if (phase_next == wsh_pkg::PH_SKIP || phase_next == wsh_pkg::PH_KEY
                             || key_bad_next) begin
                    status_next = wsh_pkg::ST_KEY_MISMATCH;
                end else begin
                    status_next = wsh_pkg::ST_OK;
                end
                consumed_next = wsh_pkg::CONS_BITS'(pos_next);
            end
        end

        if (emit) begin
            crlf_next     = '0;
            pos_next      = '0;
            space_next    = 1'b0;
            digits_next   = '0;
            code_ok_next  = 1'b1;
            phase_next    = wsh_pkg::PH_SEARCH;
            name_idx_next = '0;
            key_idx_next  = '0;
            key_bad_next  = 1'b0;
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crlf_reg      <= '0;
            pos_reg       <= '0;
            space_reg     <= 1'b0;
            digits_reg    <= '0;
            code_ok_reg   <= 1'b1;
            phase_reg     <= wsh_pkg::PH_SEARCH;
            name_idx_reg  <= '0;
            key_idx_reg   <= '0;
            key_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            crlf_reg      <= crlf_next;
            pos_reg       <= pos_next;
            space_reg     <= space_next;
            digits_reg    <= digits_next;
            code_ok_reg   <= code_ok_next;
            phase_reg     <= phase_next;
            name_idx_reg  <= name_idx_next;
            key_idx_reg   <= key_idx_next;
            key_bad_reg   <= key_bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        consumed_reg <= consumed_next;
    end

endmodule

`default_nettype wire

// ===== rtl/websocket_handshake_response_checker.sv =====
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: data_byte, tuser: mode
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: status, consumed_bytes
// cfg       in   cfg_valid / cfg_ready           cfg_index, cfg_data (accept key parts)
//
// One byte per cycle sustained while m_axis_tready does not hold the result register;
// an accepted beat is written to the queue, then taken by the back end, whose state
// update loads the result register.
// A four-entry queue separates input and result sides so either can stall alone.
// The back end takes a queued beat whenever the result register is empty or
// being drained. Synchronous active-low reset; cfg_ready is always high.
`default_nettype none

module websocket_handshake_response_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  wire logic                                s_axis_tuser,  // [0] mode
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [wsh_pkg::M_TDATA_BITS-1:0]         m_axis_tdata,  // [2:0] status,
                                                                    // [18:3] consumed_bytes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wsh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [wsh_pkg::KEY_PART_BITS-1:0]   cfg_data
);

    logic [wsh_pkg::KEY_PART_BITS-1:0] key0_reg, key1_reg, key2_reg, key3_reg;
    wsh_pkg::beat_t                    front_beat, queue_beat;
    logic                              queue_valid, back_ready;
    logic [wsh_pkg::STATUS_BITS-1:0]   status;
    logic [wsh_pkg::CONS_BITS-1:0]     consumed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wsh_pkg::REG_KEY_PART0: key0_reg <= cfg_data;
                wsh_pkg::REG_KEY_PART1: key1_reg <= cfg_data;
                wsh_pkg::REG_KEY_PART2: key2_reg <= cfg_data;
                wsh_pkg::REG_KEY_PART3: key3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    wsh_front u_front (
        .mode      (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .beat      (front_beat)
    );

    wsh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_beat   (front_beat),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_beat  (queue_beat)
    );

    wsh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key_vec      ({key3_reg, key2_reg, key1_reg, key0_reg}),
        .in_valid     (queue_valid),
        .in_ready     (back_ready),
        .beat         (queue_beat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (status),
        .out_consumed (consumed)
    );

    assign m_axis_tdata = {5'b00000, consumed, status};

endmodule

`default_nettype wire
